FILE: rtl/core/stable_priority_queue_unit_macros.svh
// Assertion helpers for the priority queue RTL.
// Both expect clk_i and rst_ni in scope.
`ifndef STABLE_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication.
`define SPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/spq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package spq_pkg;

  localparam int unsigned SpqCapacity = 64;
  localparam int unsigned SpqKeyBits  = 16;
  localparam int unsigned IdentW      = 32;
  localparam int unsigned KeyInW      = 16;
  localparam int unsigned StatusW     = 2;

  typedef enum logic {
    ACT_ENQ = 1'b0,
    ACT_DEQ = 1'b1
  } spq_act_e;

  typedef enum logic [StatusW-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } spq_status_e;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;    // insert new entry in sorted place
    logic shift;  // move every entry one cell toward the head
  } spq_cmd_t;

endpackage
`default_nettype wire

FILE: rtl/core/stable_priority_queue_unit.sv
// Stable priority queue: sorted row of entry cells, lowest key at the head.
// Input beat: action_i (0 enqueue, 1 dequeue), ident_i, key_i (low KEY_BITS
// kept). Output beat: status_o (done / empty / full), ident_out_o (dequeued
// ident, else zero) and entry_count_o (entries held after the item).
// Equal keys leave in arrival order; a new entry goes behind its equals.
// Every input beat yields exactly one output beat, registered in the cycle after accept.
// Throughput: one item per cycle while in_stall_o is low. All cells compare the new key against
// their own in parallel and shift toward tail (enqueue) or head (dequeue)
// in the same edge, so the per-item cost is one key compare plus a 4:1 mux.
// The output register decouples the sides: a new beat is taken while the
// previous result is still pending, as long as out_stall_i is low.
// When out_stall_i holds the pending result, in_stall_o rises and the
// queue contents freeze until the result is taken.
// Reset clears the entry count and the output valid; cell contents are
// not cleared, cells above the count are never read.
// Dequeue on empty and enqueue when full change nothing.
`timescale 1ns / 1ps
`default_nettype none
`include "stable_priority_queue_unit_macros.svh"
module stable_priority_queue_unit import spq_pkg::*; #(
  parameter int unsigned CAPACITY = SpqCapacity,
  parameter int unsigned KEY_BITS = SpqKeyBits,
  localparam int unsigned CntW    = $clog2(CAPACITY + 1)
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       in_valid_i,
  output logic                      in_stall_o,
  input  wire                       action_i,
  input  wire  signed [IdentW-1:0]  ident_i,
  input  wire  [KeyInW-1:0]         key_i,
  output logic                      out_valid_o,
  input  wire                       out_stall_i,
  output logic [StatusW-1:0]        status_o,
  output logic signed [IdentW-1:0]  ident_out_o,
  output logic [CntW-1:0]           entry_count_o
);

  localparam logic [CntW-1:0] CapCnt = CntW'(CAPACITY);

  logic                     in_acc;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic                     out_valid_q;
  spq_status_e              status_q, status_d;
  logic signed [IdentW-1:0] id_out_q, id_out_d;
  logic [CntW-1:0]          cnt_out_q;
  spq_cmd_t                 cmd;
  logic [KeyInW+KEY_BITS-1:0] key_ext;
  logic [KEY_BITS-1:0]      new_key;

  logic [CAPACITY-1:0]      gt;
  logic [CAPACITY-1:0]      occ;
  logic [KEY_BITS-1:0]      cell_key [CAPACITY];
  logic signed [IdentW-1:0] cell_ident [CAPACITY];

  // stall only while a finished beat waits downstream
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  // keep only the low KEY_BITS of the key, zero-extended when wider
  assign key_ext = {{KEY_BITS{1'b0}}, key_i};
  assign new_key = key_ext[KEY_BITS-1:0];

  always_comb begin
    cmd      = '0;
    cnt_d    = cnt_q;
    status_d = ST_DONE;
    id_out_d = '0;
    if (in_acc) begin
      unique case (spq_act_e'(action_i))
        ACT_ENQ: begin
          if (cnt_q == CapCnt) begin
            status_d = ST_FULL;
          end else begin
            cmd.ins = 1'b1;
            cnt_d   = cnt_q + CntW'(1);
          end
        end
        ACT_DEQ: begin
          if (cnt_q == '0) begin
            status_d = ST_EMPTY;
          end else begin
            cmd.shift = 1'b1;
            id_out_d  = cell_ident[0];
            cnt_d     = cnt_q - CntW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     left_gt;
    logic [KEY_BITS-1:0]      left_key, right_key;
    logic signed [IdentW-1:0] left_ident, right_ident;

    assign occ[i] = CntW'(i) < cnt_q;

    if (i == 0) begin : g_head
      assign left_gt    = 1'b0;
      assign left_key   = new_key;
      assign left_ident = ident_i;
    end else begin : g_body
      assign left_gt    = gt[i-1];
      assign left_key   = cell_key[i-1];
      assign left_ident = cell_ident[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      // tail vacates on dequeue; content beyond count is don't-care
      assign right_key   = cell_key[i];
      assign right_ident = cell_ident[i];
    end else begin : g_mid
      assign right_key   = cell_key[i+1];
      assign right_ident = cell_ident[i+1];
    end

    spq_cell #(
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .cmd_i         (cmd),
      .occ_i         (occ[i]),
      .new_key_i     (new_key),
      .new_ident_i   (ident_i),
      .left_gt_i     (left_gt),
      .left_key_i    (left_key),
      .left_ident_i  (left_ident),
      .right_key_i   (right_key),
      .right_ident_i (right_ident),
      .gt_o          (gt[i]),
      .key_o         (cell_key[i]),
      .ident_o       (cell_ident[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      status_q  <= status_d;
      id_out_q  <= id_out_d;
      cnt_out_q <= cnt_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign ident_out_o   = id_out_q;
  assign entry_count_o = cnt_out_q;

  `SPQ_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CapCnt, "entry count above capacity")
  `SPQ_ASSERT_NEXT(a_enq_grow, in_acc && !action_i && (cnt_q != CapCnt),
    cnt_q == $past(cnt_q) + CntW'(1), "enqueue did not grow the count")
  `SPQ_ASSERT_NEXT(a_deq_head, in_acc && action_i && (cnt_q != '0),
    ident_out_o == $past(cell_ident[0]), "dequeue did not return the head")
  `SPQ_ASSERT_NOW(a_sorted_head, cnt_q >= CntW'(2), cell_key[0] <= cell_key[1],
    "head cells out of order")
  `SPQ_ASSERT_NOW(a_full_cnt, out_valid_q && (status_q == ST_FULL),
    entry_count_o == CapCnt, "full status with room left")

endmodule
`default_nettype wire

FILE: rtl/core/spq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module spq_cell import spq_pkg::*; #(
  parameter int unsigned KEY_BITS = SpqKeyBits
) (
  input  wire                       clk_i,
  input  wire spq_cmd_t             cmd_i,
  input  wire                       occ_i,       // cell holds an entry
  input  wire  [KEY_BITS-1:0]       new_key_i,
  input  wire  signed [IdentW-1:0]  new_ident_i,
  input  wire                       left_gt_i,   // left neighbor yields to new entry
  input  wire  [KEY_BITS-1:0]       left_key_i,
  input  wire  signed [IdentW-1:0]  left_ident_i,
  input  wire  [KEY_BITS-1:0]       right_key_i,
  input  wire  signed [IdentW-1:0]  right_ident_i,
  output logic                      gt_o,
  output logic [KEY_BITS-1:0]       key_o,
  output logic signed [IdentW-1:0]  ident_o
);

  logic [KEY_BITS-1:0]      key_q, key_d;
  logic signed [IdentW-1:0] ident_q, ident_d;

  // empty cells count as +inf; strict compare keeps ties in arrival order
  assign gt_o = !occ_i || (key_q > new_key_i);

  always_comb begin
    key_d   = key_q;
    ident_d = ident_q;
    priority if (cmd_i.shift) begin
      key_d   = right_key_i;
      ident_d = right_ident_i;
    end else if (cmd_i.ins && left_gt_i) begin
      key_d   = left_key_i;
      ident_d = left_ident_i;
    end else if (cmd_i.ins && gt_o) begin
      key_d   = new_key_i;
      ident_d = new_ident_i;
    end else begin
      // hold
      key_d   = key_q;
      ident_d = ident_q;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    ident_q <= ident_d;
  end

  assign key_o   = key_q;
  assign ident_o = ident_q;

endmodule
`default_nettype wire

FILE: tb/stable_priority_queue_unit_tb.sv
`timescale 1ns / 1ps
module stable_priority_queue_unit_tb;
  import spq_pkg::*;

  localparam int unsigned CntW       = $clog2(SpqCapacity + 1);
  localparam int          CycleLimit = 500000;
  localparam int          HoldCycles = 300;

  // One input beat and one output beat, at the block's widths
  typedef struct {
    spq_act_e                  act;
    logic signed [IdentW-1:0]  ident;
    logic        [KeyInW-1:0]  key;
  } pq_item_t;

  typedef struct {
    spq_status_e               status;
    logic signed [IdentW-1:0]  ident;
    logic        [CntW-1:0]    count;
  } pq_result_t;

  // Clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Block ports; every input known from time zero
  logic                     in_valid_i  = 1'b0;
  logic                     action_i    = 1'b0;
  logic signed [IdentW-1:0] ident_i     = '0;
  logic        [KeyInW-1:0] key_i       = '0;
  logic                     out_stall_i = 1'b0;
  logic                     in_stall_o;
  logic                     out_valid_o;
  logic [StatusW-1:0]       status_o;
  logic signed [IdentW-1:0] ident_out_o;
  logic [CntW-1:0]          entry_count_o;

  stable_priority_queue_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .ident_i      (ident_i),
    .key_i        (key_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .ident_out_o  (ident_out_o),
    .entry_count_o(entry_count_o)
  );

  // Items waiting to be offered, and results the queue model says are due
  pq_item_t   stimulus_q[$];
  pq_result_t awaited_q[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_asked     = 0;
  int hold_served    = 0;
  int hold_left      = 0;
  int mismatch_cnt   = 0;
  int cycle_cnt      = 0;
  bit beat_taken     = 1'b0;

  // ---------------------------------------------------------------------------
  // Queue model: sorted row, lowest key at index 0, ties kept in arrival order.
  // Only entries below held_count are ever read.
  // ---------------------------------------------------------------------------
  logic signed [IdentW-1:0] held_ident[SpqCapacity];
  logic [31:0]              held_key[SpqCapacity];
  int                       held_count = 0;

  function automatic pq_result_t serve_item(pq_item_t it);
    pq_result_t  r;
    logic [31:0] k;
    int          pos;
    k        = 32'(it.key) & ((32'd1 << SpqKeyBits) - 32'd1);
    r.status = ST_DONE;
    r.ident  = '0;
    if (it.act == ACT_ENQ) begin
      if (held_count >= SpqCapacity) begin
        r.status = ST_FULL;
      end else begin
        // new entry lands behind every held entry with key <= its own
        pos = held_count;
        while (pos > 0 && held_key[pos-1] > k) begin
          held_ident[pos] = held_ident[pos-1];
          held_key[pos]   = held_key[pos-1];
          pos--;
        end
        held_ident[pos] = it.ident;
        held_key[pos]   = k;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.ident = held_ident[0];
        for (int i = 1; i < held_count; i++) begin
          held_ident[i-1] = held_ident[i];
          held_key[i-1]   = held_key[i];
        end
        held_count--;
      end
    end
    r.count = CntW'(held_count);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
    mismatch_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // Input side. The accept check runs at the rising edge; the next beat is
  // put on the pins at the falling edge. A beat that was not taken stays put.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    beat_taken = rst_ni && in_valid_i && !in_stall_o;
    if (beat_taken) begin
      awaited_q.push_back(serve_item(stimulus_q[0]));
      void'(stimulus_q.pop_front());
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || beat_taken) begin
      if (stimulus_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        action_i   <= stimulus_q[0].act;
        ident_i    <= stimulus_q[0].ident;
        key_i      <= stimulus_q[0].key;
      end else begin
        // idle: payload wanders so the block cannot lean on it
        in_valid_i <= 1'b0;
        action_i   <= 1'($urandom);
        ident_i    <= $urandom;
        key_i      <= KeyInW'($urandom);
      end
    end
  end

  // Output side stall: random, or a long hold-off when one is requested so
  // the result register backs up and in_stall_o has to rise.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_served != hold_asked) begin
      hold_served <= hold_asked;
      hold_left   <= HoldCycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Output beats are checked in order against the oldest awaited result
  always @(posedge clk_i) begin : check_results
    pq_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_q.size() == 0) begin
        report_mismatch("unexpected output beat", status_o, -1);
      end else begin
        want = awaited_q.pop_front();
        if (status_o !== want.status)
          report_mismatch("status", status_o, want.status);
        if (ident_out_o !== want.ident)
          report_mismatch("ident_out", ident_out_o, want.ident);
        if (entry_count_o !== want.count)
          report_mismatch("entry_count", entry_count_o, want.count);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic add_item(spq_act_e act, logic signed [IdentW-1:0] id,
                          logic [KeyInW-1:0] k);
    pq_item_t it;
    it.act   = act;
    it.ident = id;
    it.key   = k;
    stimulus_q.push_back(it);
  endtask

  // Bursts with a bias: fill runs push the queue into its full state, drain
  // runs empty it, mixed runs churn the middle. Narrow key ranges force ties.
  task automatic add_bursts(int n_items);
    int made, len, enq_pct, key_mode;
    logic [KeyInW-1:0] k;
    made = 0;
    while (made < n_items) begin
      case ((made == 0) ? 0 : $urandom_range(0, 3))
        0: enq_pct = 95;
        1: enq_pct = 10;
        2: enq_pct = 50;
        default: enq_pct = 60;
      endcase
      len      = (made == 0) ? 72 : $urandom_range(20, 90);
      key_mode = $urandom_range(0, 2);
      for (int i = 0; i < len; i++) begin
        case (key_mode)
          0: k = KeyInW'($urandom_range(0, 7));
          1: k = KeyInW'($urandom);
          default: k = $urandom_range(0, 1) ? KeyInW'($urandom_range(0, 3))
                                            : KeyInW'($urandom_range(16'hFFFC, 16'hFFFF));
        endcase
        add_item(($urandom_range(0, 99) < enq_pct) ? ACT_ENQ : ACT_DEQ, $urandom, k);
      end
      made += len;
    end
  endtask

  task automatic drain_stimulus();
    while (stimulus_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, int n_items);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    add_bursts(n_items);
    drain_stimulus();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty dequeue, field extremes, equal-key ordering, drain past empty
    add_item(ACT_DEQ, 32'sh7FFF_FFFF, 16'hFFFF);
    add_item(ACT_ENQ, 32'sh7FFF_FFFF, 16'hFFFF);
    add_item(ACT_ENQ, 32'sh8000_0000, 16'h0000);
    add_item(ACT_ENQ, 32'sh0000_0000, 16'h8000);
    add_item(ACT_ENQ, -32'sd1,        16'h0000);
    add_item(ACT_ENQ, 32'sh0000_0001, 16'h8000);
    add_item(ACT_ENQ, 32'sh0000_0002, 16'hFFFF);
    add_item(ACT_ENQ, 32'sh5555_5555, 16'h5555);
    add_item(ACT_ENQ, 32'shAAAA_AAAA, 16'hAAAA);
    for (int i = 0; i < 9; i++) add_item(ACT_DEQ, $urandom, KeyInW'($urandom));
    add_item(ACT_DEQ, 32'sh0, 16'h0);
    drain_stimulus();

    // Long hold-off on the output while the sender keeps offering beats
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_asked++;
    add_bursts(120);
    drain_stimulus();

    run_phase(0, 0, 280);
    run_phase(79, 0, 300);
    run_phase(0, 79, 300);
    run_phase(34, 34, 300);

    while (awaited_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/stable_priority_queue_unit.sv
tb/stable_priority_queue_unit_tb.sv
